// ===== src/frb_pkg.sv =====
// Shared constants, field widths, status codes and sweep types of the reassembly buffer.
package frb_pkg;

   localparam int MAX_PACKET_BYTES = 2048;
   localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
   localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

   // The received bitmap is kept in rows of 32 marks.
   localparam int ROW_BITS = 32;
   localparam int ROW_W = $clog2(ROW_BITS);
   localparam int ROWS = MAX_PACKET_BYTES / ROW_BITS;
   localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ROW_CNT_W = $clog2(ROW_BITS + 1);

   localparam int FUNC_W = 1;
   localparam int TLEN_W = 12;
   localparam int OFF_W = 11;
   localparam int FLEN_W = 12;
   localparam int BIDX_W = 11;
   localparam int DATA_W = 8;
   localparam int RADDR_W = 11;
   localparam int STATUS_W = 3;
   localparam int RCNT_W = 12;

   typedef logic [FUNC_W-1:0] func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [ROW_IDX_W-1:0] row_idx_type;
   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [ROW_CNT_W-1:0] row_cnt_type;

   localparam func_type FUNC_BYTE = 1'b0;
   localparam func_type FUNC_READ = 1'b1;

   localparam status_type STATUS_OK = 3'd0;
   localparam status_type STATUS_CONFLICT = 3'd1;
   localparam status_type STATUS_NEW_LENGTH = 3'd2;
   localparam status_type STATUS_REJECTED = 3'd3;
   localparam status_type STATUS_READ = 3'd4;

   typedef struct packed {
      logic start;
      addr_type lo;
      addr_type hi;
   } frb_sweep_cmd_type;

   typedef struct packed {
      logic busy;
      row_idx_type rd_row;
      logic wr_en;
      row_idx_type wr_row;
      row_type wr_data;
      row_cnt_type row_count;
      logic last;
   } frb_sweep_stat_type;

endpackage

// ===== src/frb_if.sv =====
// Request and response channel interfaces of the reassembly buffer.
interface frb_req_if;
   import frb_pkg::*;

   logic valid;
   logic ready;
   logic [FUNC_W-1:0] func;
   logic [TLEN_W-1:0] total_length;
   logic [OFF_W-1:0] frag_offset;
   logic [FLEN_W-1:0] frag_length;
   logic [BIDX_W-1:0] byte_index;
   logic [DATA_W-1:0] data_byte;
   logic [RADDR_W-1:0] read_address;

   modport source (
      output valid, func, total_length, frag_offset, frag_length, byte_index, data_byte,
             read_address,
      input ready
   );
   modport sink (
      input valid, func, total_length, frag_offset, frag_length, byte_index, data_byte,
            read_address,
      output ready
   );
endinterface

interface frb_rsp_if;
   import frb_pkg::*;

   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic complete;
   logic [RCNT_W-1:0] received_count;
   logic [DATA_W-1:0] read_byte;

   modport source (output valid, status, complete, received_count, read_byte, input ready);
   modport sink (input valid, status, complete, received_count, read_byte, output ready);
endinterface

// ===== src/fragment_reassembly_buffer.sv =====
// Reassembly buffer top: an accepted word passes stage one, where memory data is valid, then the
// response register. Throughput is one word per cycle while bytes store, match or are read
// and the response channel does not stall. A restart (first byte, new length or conflict)
// holds the input while the bitmap sweep clears and recounts one 32-bit row per cycle.
// After reset the same sweep clears the bitmap; no word is accepted until it has finished.
module fragment_reassembly_buffer (
   input logic clock,
   input logic reset,
   frb_req_if.sink req_chan,
   frb_rsp_if.source rsp_chan
);
   import frb_pkg::*;

   logic req_fire;
   logic req_ready;
   logic [11:0] pos_sum;
   logic [12:0] end_sum;
   logic req_bad;
   addr_type req_addr;
   logic req_addr_ok;

   // Stage one: memory data is valid here.
   logic s1_valid_ff;
   func_type s1_func_ff;
   logic [TLEN_W-1:0] s1_tlen_ff;
   addr_type s1_lo_ff;
   addr_type s1_addr_ff;
   logic s1_first_ff;
   logic s1_bad_ff;
   logic s1_addr_ok_ff;
   logic [DATA_W-1:0] s1_data_ff;

   logic [TLEN_W-1:0] plen_ff;
   logic [CNT_W-1:0] total_ff;
   logic rej_ff;
   logic pend_ff;
   status_type pend_status_ff;

   // Last writes, forwarded to the next word whose read was already in flight.
   logic bf_valid_ff;
   addr_type bf_addr_ff;
   logic [DATA_W-1:0] bf_data_ff;
   logic mf_valid_ff;
   row_idx_type mf_row_ff;
   row_type mf_data_ff;

   logic rsp_valid_ff;
   status_type rsp_status_ff;
   logic rsp_complete_ff;
   logic [RCNT_W-1:0] rsp_count_ff;
   logic [DATA_W-1:0] rsp_byte_ff;

   logic [DATA_W-1:0] byte_rd;
   row_type mark_rd;
   row_idx_type s1_row_idx;
   logic [ROW_W-1:0] s1_bit;
   logic [DATA_W-1:0] s1_byte;
   row_type s1_row;
   logic s1_mark;
   logic rej_next;
   status_type status;
   logic byte_we;
   logic mark_we;
   logic restart;
   logic [TLEN_W-1:0] plen_next;
   logic [CNT_W-1:0] total_next;
   logic complete_next;
   logic out_free;
   logic s1_go;
   logic [CNT_W-1:0] sweep_total;

   logic byte_we_g;
   logic mark_we_g;
   addr_type byte_ra;
   row_idx_type mark_ra;
   logic mark_wen;
   row_idx_type mark_wa;
   row_type mark_wd;

   frb_sweep_cmd_type sw_cmd;
   frb_sweep_stat_type sw_stat;

   assign req_fire = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   always_comb begin
      pos_sum = 12'(req_chan.frag_offset) + 12'(req_chan.byte_index);
      end_sum = 13'(req_chan.frag_offset) + 13'(req_chan.frag_length);
      req_bad = (req_chan.total_length == '0) ||
                (32'(req_chan.total_length) > MAX_PACKET_BYTES) ||
                (req_chan.frag_length == '0) ||
                (end_sum > 13'(req_chan.total_length)) ||
                (12'(req_chan.byte_index) >= req_chan.frag_length);
      req_addr = (req_chan.func == FUNC_READ) ? ADDR_W'(req_chan.read_address) :
                                                ADDR_W'(pos_sum);
      req_addr_ok = 32'(req_chan.read_address) < MAX_PACKET_BYTES;
   end

   assign s1_row_idx = ROW_IDX_W'(s1_addr_ff >> ROW_W);
   assign s1_bit = s1_addr_ff[ROW_W-1:0];

   always_comb begin
      s1_byte = (bf_valid_ff && (bf_addr_ff == s1_addr_ff)) ? bf_data_ff : byte_rd;
      s1_row = (mf_valid_ff && (mf_row_ff == s1_row_idx)) ? mf_data_ff : mark_rd;
      s1_mark = s1_row[s1_bit];
      rej_next = s1_first_ff ? s1_bad_ff : (rej_ff || s1_bad_ff);

      status = STATUS_OK;
      byte_we = 1'b0;
      mark_we = 1'b0;
      restart = 1'b0;
      plen_next = plen_ff;
      total_next = total_ff;
      if (s1_func_ff == FUNC_READ) begin
         status = STATUS_READ;
      end else if (rej_next) begin
         status = STATUS_REJECTED;
      end else if (plen_ff == '0) begin
         restart = 1'b1;
         byte_we = 1'b1;
         mark_we = 1'b1;
         plen_next = s1_tlen_ff;
      end else if (s1_tlen_ff != plen_ff) begin
         status = STATUS_NEW_LENGTH;
         restart = 1'b1;
         byte_we = 1'b1;
         mark_we = 1'b1;
         plen_next = s1_tlen_ff;
      end else if (s1_mark) begin
         if (s1_byte != s1_data_ff) begin
            status = STATUS_CONFLICT;
            restart = 1'b1;
            byte_we = 1'b1;
         end
      end else begin
         byte_we = 1'b1;
         mark_we = 1'b1;
         total_next = total_ff + 1'b1;
      end
      complete_next = (plen_next != '0) && (32'(total_next) == 32'(plen_next));
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_go = s1_valid_ff && out_free;
   assign req_ready = !sw_stat.busy && (!s1_valid_ff || (s1_go && !restart));
   assign sweep_total = total_ff + CNT_W'(sw_stat.row_count);

   assign byte_we_g = s1_go && byte_we;
   assign mark_we_g = s1_go && mark_we;

   always_comb begin
      byte_ra = req_fire ? req_addr : s1_addr_ff;
      if (sw_stat.busy) begin
         mark_ra = sw_stat.rd_row;
      end else begin
         mark_ra = req_fire ? ROW_IDX_W'(req_addr >> ROW_W) : s1_row_idx;
      end
      mark_wen = sw_stat.wr_en || mark_we_g;
      mark_wa = sw_stat.wr_en ? sw_stat.wr_row : s1_row_idx;
      mark_wd = sw_stat.wr_en ? sw_stat.wr_data : (s1_row | (row_type'(1) << s1_bit));
   end

   always_comb begin
      sw_cmd.start = s1_go && restart;
      sw_cmd.lo = s1_lo_ff;
      sw_cmd.hi = s1_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         plen_ff <= '0;
         total_ff <= '0;
         rej_ff <= 1'b0;
         pend_ff <= 1'b0;
         bf_valid_ff <= 1'b0;
         mf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_go) begin
            plen_ff <= plen_next;
            if (s1_func_ff == FUNC_BYTE) begin
               rej_ff <= rej_next;
            end
         end

         if (s1_go && restart) begin
            total_ff <= '0;
         end else if (sw_stat.wr_en) begin
            total_ff <= sweep_total;
         end else if (s1_go) begin
            total_ff <= total_next;
         end

         if (s1_go && restart) begin
            pend_ff <= 1'b1;
            pend_status_ff <= status;
         end else if (sw_stat.last) begin
            pend_ff <= 1'b0;
         end

         if (byte_we_g) begin
            bf_valid_ff <= 1'b1;
            bf_addr_ff <= s1_addr_ff;
            bf_data_ff <= s1_data_ff;
         end

         // The sweep rewrites rows, so a forwarded row is stale afterwards.
         if (sw_stat.wr_en) begin
            mf_valid_ff <= 1'b0;
         end else if (mark_we_g) begin
            mf_valid_ff <= 1'b1;
            mf_row_ff <= s1_row_idx;
            mf_data_ff <= mark_wd;
         end

         if (s1_go && !restart) begin
            rsp_valid_ff <= 1'b1;
            rsp_status_ff <= status;
            rsp_complete_ff <= complete_next;
            rsp_count_ff <= RCNT_W'(total_next);
            rsp_byte_ff <= ((s1_func_ff == FUNC_READ) && s1_addr_ok_ff) ? s1_byte : '0;
         end else if (sw_stat.last && pend_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_status_ff <= pend_status_ff;
            rsp_complete_ff <= (plen_ff != '0) && (32'(sweep_total) == 32'(plen_ff));
            rsp_count_ff <= RCNT_W'(sweep_total);
            rsp_byte_ff <= '0;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         s1_func_ff <= req_chan.func;
         s1_tlen_ff <= req_chan.total_length;
         s1_lo_ff <= ADDR_W'(req_chan.frag_offset);
         s1_addr_ff <= req_addr;
         s1_first_ff <= (req_chan.byte_index == '0);
         s1_bad_ff <= req_bad;
         s1_addr_ok_ff <= req_addr_ok;
         s1_data_ff <= req_chan.data_byte;
      end
   end

   frb_ram #(
      .WIDTH(DATA_W),
      .DEPTH(MAX_PACKET_BYTES)
   ) u_byte_ram (
      .clock(clock),
      .wr_en(byte_we_g),
      .wr_addr(s1_addr_ff),
      .wr_data(s1_data_ff),
      .rd_addr(byte_ra),
      .rd_data(byte_rd)
   );

   frb_ram #(
      .WIDTH(ROW_BITS),
      .DEPTH(ROWS)
   ) u_mark_ram (
      .clock(clock),
      .wr_en(mark_wen),
      .wr_addr(mark_wa),
      .wr_data(mark_wd),
      .rd_addr(mark_ra),
      .rd_data(mark_rd)
   );

   frb_sweep u_sweep (
      .clock(clock),
      .reset(reset),
      .cmd(sw_cmd),
      .rd_data(mark_rd),
      .stat(sw_stat)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.complete = rsp_complete_ff;
   assign rsp_chan.received_count = rsp_count_ff;
   assign rsp_chan.read_byte = rsp_byte_ff;

endmodule

// ===== src/frb_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module frb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input logic clock,
   input logic wr_en,
   input logic [AW-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [AW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/frb_sweep.sv =====
// Bitmap sweep engine: clears marks outside a kept range and recounts the kept marks row by row.
module frb_sweep (
   input logic clock,
   input logic reset,
   input frb_pkg::frb_sweep_cmd_type cmd,
   input frb_pkg::row_type rd_data,
   output frb_pkg::frb_sweep_stat_type stat
);
   import frb_pkg::*;

   typedef enum logic {SW_IDLE, SW_RUN} sweep_state_type;

   localparam row_idx_type LAST_ROW = ROW_IDX_W'(ROWS - 1);
   localparam logic [ROW_W-1:0] TOP_BIT = ROW_W'(ROW_BITS - 1);
   localparam int GROUPS = ROW_BITS / 8;

   sweep_state_type state_ff;
   row_idx_type rd_row_ff;
   logic wr_valid_ff;
   row_idx_type wr_row_ff;
   logic clear_all_ff;
   addr_type lo_ff;
   addr_type hi_ff;

   row_idx_type lo_row;
   row_idx_type hi_row;
   logic [ROW_W-1:0] lo_bit;
   logic [ROW_W-1:0] hi_bit;
   row_type lo_mask;
   row_type hi_mask;
   row_type keep;
   row_type kept;
   row_cnt_type count;
   logic [3:0] group_count;

   // Reset starts a full clearing pass; a command starts a range-keeping pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SW_RUN;
         rd_row_ff <= '0;
         wr_valid_ff <= 1'b0;
         clear_all_ff <= 1'b1;
      end else begin
         wr_valid_ff <= (state_ff == SW_RUN);
         wr_row_ff <= rd_row_ff;
         unique case (state_ff)
            SW_IDLE: begin
               if (cmd.start) begin
                  state_ff <= SW_RUN;
                  rd_row_ff <= '0;
                  clear_all_ff <= 1'b0;
                  lo_ff <= cmd.lo;
                  hi_ff <= cmd.hi;
               end
            end
            SW_RUN: begin
               rd_row_ff <= rd_row_ff + 1'b1;
               if (rd_row_ff == LAST_ROW) begin
                  state_ff <= SW_IDLE;
               end
            end
            default: state_ff <= SW_IDLE;
         endcase
      end
   end

   assign lo_row = ROW_IDX_W'(lo_ff >> ROW_W);
   assign hi_row = ROW_IDX_W'(hi_ff >> ROW_W);
   assign lo_bit = lo_ff[ROW_W-1:0];
   assign hi_bit = hi_ff[ROW_W-1:0];

   always_comb begin
      lo_mask = '1;
      hi_mask = '1;
      if (wr_row_ff == lo_row) begin
         lo_mask = {ROW_BITS{1'b1}} << lo_bit;
      end
      if (wr_row_ff == hi_row) begin
         hi_mask = {ROW_BITS{1'b1}} >> (TOP_BIT - hi_bit);
      end
      keep = lo_mask & hi_mask;
      if (clear_all_ff || (wr_row_ff < lo_row) || (wr_row_ff > hi_row)) begin
         keep = '0;
      end
      kept = rd_data & keep;

      // Population count in byte-wide groups, then a sum of the groups.
      count = '0;
      for (int g = 0; g < GROUPS; g++) begin
         group_count = '0;
         for (int b = 0; b < 8; b++) begin
            group_count = group_count + 4'(kept[g * 8 + b]);
         end
         count = count + ROW_CNT_W'(group_count);
      end
   end

   always_comb begin
      stat.busy = (state_ff == SW_RUN) || wr_valid_ff;
      stat.rd_row = rd_row_ff;
      stat.wr_en = wr_valid_ff;
      stat.wr_row = wr_row_ff;
      stat.wr_data = kept;
      stat.row_count = count;
      stat.last = wr_valid_ff && (wr_row_ff == LAST_ROW);
   end

endmodule
